/* hdl/btset_pkg.sv */
// Shared constants, state type and a byte helper for the basename trigram set.
package btset_pkg;

    localparam int MAX_CODES = 64;
    localparam int CODE_W    = 24;
    localparam int BYTE_W    = 8;
    localparam int PAIR_W    = 2 * BYTE_W;
    localparam int CNT_W     = $clog2(MAX_CODES + 1);
    localparam int ADDR_W    = $clog2(MAX_CODES);
    localparam int SEG_W     = 2;

    localparam logic [BYTE_W-1:0] SEP_BYTE = 8'h2F;
    localparam logic [BYTE_W-1:0] UPPER_LO = 8'h41;
    localparam logic [BYTE_W-1:0] UPPER_HI = 8'h5A;
    localparam logic [BYTE_W-1:0] CASE_GAP = 8'd32;

    localparam logic [SEG_W-1:0] SEG_SAT    = 2'd3;
    localparam logic [SEG_W-1:0] SEG_WINDOW = 2'd2;

    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(MAX_CODES);
    localparam logic [CNT_W-1:0] CNT_ONE  = CNT_W'(1);

    typedef enum logic [2:0] {
        S_IDLE,
        S_SRCH_RD,
        S_SRCH_CMP,
        S_SHIFT_RD,
        S_SHIFT_WR,
        S_EMIT_RD,
        S_EMIT_LD,
        S_EMIT_HOLD
    } t_state;

    // Fold A..Z to a..z, everything else passes.
    function automatic logic [BYTE_W-1:0] lower_byte(input logic [BYTE_W-1:0] b);
        logic [BYTE_W-1:0] r;
        r = b;
        if (b >= UPPER_LO && b <= UPPER_HI) begin
            r = b + CASE_GAP;
        end
        return r;
    endfunction

endpackage

/* hdl/btset_ram.sv */
// Generic simple dual-port RAM, one write port, one registered read port.
module btset_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

/* hdl/basename_trigram_set.sv */
// Top level: trigram code set of the last path component, emitted sorted.
//
// Feed a path one byte per input transaction; assert end_of_path on the last
// one (has_byte may be 0 there, or on an empty path). A '/' drops everything
// gathered so far, A..Z fold to lower case, and from the third byte of a
// component each byte closes a 24-bit window (oldest byte high) that goes
// into a sorted, duplicate-free set of up to MAX_CODES codes held in one
// simple dual-port RAM. A byte that closes no window is taken without a
// stall. A byte that closes a window walks the RAM through one shared
// compare: each entry below the new code is read and compared in turn, each
// larger entry is read and shifted up by one place, then the new code is
// written; a duplicate ends the walk early. The single RAM read port makes
// the walk go entry by entry, and o_stall stays high for that whole walk.
// On end_of_path the set goes out in ascending order, each result held
// until the downstream stall drops before the next one is read, the last
// one flagged is_final; an empty or short basename gives a single
// transaction with no_codes set and code 0. Codes of the last component
// that do not fit are dropped and every result carries overflowed. All
// state returns to reset after the final result is taken.
module basename_trigram_set (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    // input channel
    input  logic                             i_valid,
    output logic                             o_stall,
    input  logic                             i_has_byte,
    input  logic [btset_pkg::BYTE_W-1:0]     i_path_byte,
    input  logic                             i_end_of_path,
    // result channel
    output logic                             o_valid,
    input  logic                             i_stall,
    output logic [btset_pkg::CODE_W-1:0]     o_trigram_code,
    output logic                             o_is_final,
    output logic                             o_no_codes,
    output logic                             o_overflowed
);

    import btset_pkg::*;

    // sequencer and path state
    t_state              r_state,   n_state;
    logic [PAIR_W-1:0]   r_recent,  n_recent;
    logic [SEG_W-1:0]    r_seg,     n_seg;
    logic [CNT_W-1:0]    r_count,   n_count;
    logic                r_ovf,     n_ovf;
    logic                r_eop,     n_eop;
    // walk registers: r_idx scans / emits, r_sh is the shift destination
    logic [CNT_W-1:0]    r_idx,     n_idx;
    logic [CNT_W-1:0]    r_sh,      n_sh;
    logic [CODE_W-1:0]   r_code,    n_code;
    // output register
    logic                r_out_valid, n_out_valid;
    logic [CODE_W-1:0]   r_out_code,  n_out_code;
    logic                r_out_final, n_out_final;
    logic                r_out_none,  n_out_none;
    logic                r_out_ovf,   n_out_ovf;

    // code RAM ports
    logic                ram_we;
    logic [ADDR_W-1:0]   ram_waddr;
    logic [CODE_W-1:0]   ram_wdata;
    logic [ADDR_W-1:0]   ram_raddr;
    logic [CODE_W-1:0]   ram_rdata;

    logic                in_acc;
    logic [BYTE_W-1:0]   low_byte;

    btset_ram #(
        .WIDTH (CODE_W),
        .DEPTH (MAX_CODES)
    ) u_codes (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    assign o_stall  = (r_state != S_IDLE);
    assign in_acc   = i_valid && !o_stall;
    assign low_byte = lower_byte(i_path_byte);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_recent    <= '0;
            r_seg       <= '0;
            r_count     <= '0;
            r_ovf       <= 1'b0;
            r_eop       <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_recent    <= n_recent;
            r_seg       <= n_seg;
            r_count     <= n_count;
            r_ovf       <= n_ovf;
            r_eop       <= n_eop;
            r_out_valid <= n_out_valid;
        end
        r_idx      <= n_idx;
        r_sh       <= n_sh;
        r_code     <= n_code;
        r_out_code <= n_out_code;
        r_out_final <= n_out_final;
        r_out_none <= n_out_none;
        r_out_ovf  <= n_out_ovf;
    end

    always_comb begin
        logic ins_done;   // insert walk finished (inserted, duplicate or dropped)
        logic go_emit;
        logic at_pos;     // insert point found at r_idx

        n_state     = r_state;
        n_recent    = r_recent;
        n_seg       = r_seg;
        n_count     = r_count;
        n_ovf       = r_ovf;
        n_eop       = r_eop;
        n_idx       = r_idx;
        n_sh        = r_sh;
        n_code      = r_code;
        n_out_valid = r_out_valid;
        n_out_code  = r_out_code;
        n_out_final = r_out_final;
        n_out_none  = r_out_none;
        n_out_ovf   = r_out_ovf;

        ram_we    = 1'b0;
        ram_waddr = r_sh[ADDR_W-1:0];
        ram_wdata = ram_rdata;
        ram_raddr = r_idx[ADDR_W-1:0];

        ins_done = 1'b0;
        go_emit  = 1'b0;
        at_pos   = 1'b0;

        unique case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    n_eop   = i_end_of_path;
                    go_emit = i_end_of_path;
                    if (i_has_byte) begin
                        if (i_path_byte == SEP_BYTE) begin
                            n_recent = '0;
                            n_seg    = '0;
                            n_count  = '0;
                            n_ovf    = 1'b0;
                        end else begin
                            n_recent = {r_recent[BYTE_W-1:0], low_byte};
                            if (r_seg != SEG_SAT) begin
                                n_seg = r_seg + SEG_W'(1);
                            end
                            if (r_seg >= SEG_WINDOW) begin
                                n_code  = {r_recent, low_byte};
                                n_idx   = '0;
                                n_state = S_SRCH_RD;
                                go_emit = 1'b0;
                            end
                        end
                    end
                    if (go_emit) begin
                        n_idx   = '0;
                        n_state = S_EMIT_RD;
                    end
                end
            end

            S_SRCH_RD: begin
                if (r_idx == r_count) begin
                    at_pos = 1'b1;
                end else begin
                    n_state = S_SRCH_CMP;
                end
            end

            S_SRCH_CMP: begin
                if (ram_rdata < r_code) begin
                    n_idx   = r_idx + CNT_ONE;
                    n_state = S_SRCH_RD;
                end else if (ram_rdata == r_code) begin
                    ins_done = 1'b1;
                end else begin
                    at_pos = 1'b1;
                end
            end

            S_SHIFT_RD: begin
                if (r_sh == r_idx) begin
                    ram_we    = 1'b1;
                    ram_waddr = r_idx[ADDR_W-1:0];
                    ram_wdata = r_code;
                    n_count   = r_count + CNT_ONE;
                    ins_done  = 1'b1;
                end else begin
                    ram_raddr = r_sh[ADDR_W-1:0] - ADDR_W'(1);
                    n_state   = S_SHIFT_WR;
                end
            end

            S_SHIFT_WR: begin
                ram_we  = 1'b1;
                n_sh    = r_sh - CNT_ONE;
                n_state = S_SHIFT_RD;
            end

            S_EMIT_RD: begin
                if (r_count == '0) begin
                    n_out_valid = 1'b1;
                    n_out_code  = '0;
                    n_out_final = 1'b1;
                    n_out_none  = 1'b1;
                    n_out_ovf   = r_ovf;
                    n_state     = S_EMIT_HOLD;
                end else begin
                    n_state = S_EMIT_LD;
                end
            end

            S_EMIT_LD: begin
                n_out_valid = 1'b1;
                n_out_code  = ram_rdata;
                n_out_final = ((r_idx + CNT_ONE) == r_count);
                n_out_none  = 1'b0;
                n_out_ovf   = r_ovf;
                n_state     = S_EMIT_HOLD;
            end

            S_EMIT_HOLD: begin
                if (!i_stall) begin
                    n_out_valid = 1'b0;
                    if (r_out_final) begin
                        n_recent = '0;
                        n_seg    = '0;
                        n_count  = '0;
                        n_ovf    = 1'b0;
                        n_eop    = 1'b0;
                        n_state  = S_IDLE;
                    end else begin
                        n_idx   = r_idx + CNT_ONE;
                        n_state = S_EMIT_RD;
                    end
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase

        // new code belongs at r_idx: drop it if full, else open a gap
        if (at_pos) begin
            if (r_count == CNT_FULL) begin
                n_ovf    = 1'b1;
                ins_done = 1'b1;
            end else begin
                n_sh    = r_count;
                n_state = S_SHIFT_RD;
            end
        end

        if (ins_done) begin
            if (r_eop) begin
                n_idx   = '0;
                n_state = S_EMIT_RD;
            end else begin
                n_state = S_IDLE;
            end
        end
    end

    assign o_valid        = r_out_valid;
    assign o_trigram_code = r_out_code;
    assign o_is_final     = r_out_final;
    assign o_no_codes     = r_out_none;
    assign o_overflowed   = r_out_ovf;

endmodule
